FILE: design/bcdl_pkg.sv
// bcdl_pkg: shared constants, phase codes and types of the button detector
// no dependencies
`timescale 1ns / 1ps

package bcdl_pkg;

    localparam int KEYS       = 4;
    localparam int LEVEL_W    = 4;
    localparam int IDX_W      = 3;
    localparam int CNT_W      = 16;
    localparam int EV_W       = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CNT_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [CNT_W-1:0] DOUBLE_RST   = 16'd250;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE   = 2'd2;

    // request codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // per-key phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_DEBOUNCE = 3'd1;
    localparam logic [2:0] PH_HELD     = 3'd2;
    localparam logic [2:0] PH_GAP      = 3'd3;
    localparam logic [2:0] PH_WAIT     = 3'd4;

    // event flag bits
    localparam logic [EV_W-1:0] EV_CLICK  = 3'b001;
    localparam logic [EV_W-1:0] EV_DOUBLE = 3'b010;
    localparam logic [EV_W-1:0] EV_LONG   = 3'b100;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] double_click_ticks;
    } t_cfg;

    typedef struct packed {
        logic [EV_W-1:0]    event_flags;
        logic [LEVEL_W-1:0] held_keys;
    } t_result;

endpackage

FILE: design/bcdl_key.sv
// bcdl_key: debounce / click / double-click / long-press machine of one key
// depends on bcdl_pkg
`timescale 1ns / 1ps

module bcdl_key
    import bcdl_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  logic            i_tick,
    input  logic            i_level,
    input  logic            i_clear,
    output logic [EV_W-1:0] o_events,
    output logic            o_held_next
);

    logic [2:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [EV_W-1:0]  r_events, n_events;
    logic             r_held, n_held;
    logic [CNT_W-1:0] cnt_dec;
    logic             cnt_zero;

    assign cnt_dec  = r_cnt - 1'b1;
    assign cnt_zero = (cnt_dec == '0);

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_events = r_events;
        n_held   = r_held;
        case (r_phase)
            PH_DEBOUNCE: begin
                if (!i_level) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_cnt = cnt_dec;
                    if (cnt_zero) begin
                        n_held  = 1'b1;
                        n_cnt   = i_cfg.long_press_ticks;
                        n_phase = PH_HELD;
                    end
                end
            end
            PH_HELD: begin
                if (!i_level) begin
                    n_held  = 1'b0;
                    n_cnt   = i_cfg.double_click_ticks;
                    n_phase = PH_GAP;
                end else begin
                    n_cnt = cnt_dec;
                    if (cnt_zero) begin
                        n_events = r_events | EV_LONG;
                        n_phase  = PH_WAIT;
                    end
                end
            end
            PH_GAP: begin
                if (i_level) begin
                    n_events = r_events | EV_DOUBLE;
                    n_held   = 1'b1;
                    n_phase  = PH_WAIT;
                end else begin
                    n_cnt = cnt_dec;
                    if (cnt_zero) begin
                        n_events = r_events | EV_CLICK;
                        n_phase  = PH_IDLE;
                    end
                end
            end
            PH_WAIT: begin
                if (!i_level) begin
                    n_held  = 1'b0;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                if (i_level) begin
                    n_cnt   = i_cfg.debounce_ticks;
                    n_phase = PH_DEBOUNCE;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cnt    <= '0;
            r_events <= '0;
            r_held   <= 1'b0;
        end else if (i_tick) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_events <= n_events;
            r_held   <= n_held;
        end else if (i_clear) begin
            r_events <= '0;
        end
    end

    assign o_events    = r_events;
    assign o_held_next = i_tick ? n_held : r_held;

endmodule

FILE: design/bcdl_oskid.sv
// bcdl_oskid: result register with a skid stage so requests keep flowing
// depends on bcdl_pkg
`timescale 1ns / 1ps

module bcdl_oskid
    import bcdl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_data,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_data,
    output logic    o_busy
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_load;
            r_skid_valid <= 1'b0;
        end else if (i_load) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_load) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_busy  = r_skid_valid;

endmodule

FILE: design/button_click_double_long_detector.sv
// button_click_double_long_detector: top level, config registers and key array
// depends on bcdl_pkg, bcdl_key, bcdl_oskid
`timescale 1ns / 1ps

// Usage
// Input channel (i_valid / o_stall) carries one request per cycle while o_stall is low:
//   tick (action 0): pressed levels of all keys, every key machine advances
//   read (action 1): returns the pending flags of key i_key_index and clears
//     them; an index at or above the key count returns zero
// Output channel (o_valid / i_stall) returns one result per request:
//   event flags (zero on a tick) and the debounced held state after it.
// Results are registered. Throughput is one request per cycle while o_stall
// is low, set by the combinational next-state logic of the key machines.
// When the receiver stalls, the held result stays put and one more request
// is absorbed by the skid stage; o_stall then rises until the result drains.
// Reset (synchronous, active low) returns every key to idle with no flags,
// loads the default timer counts and empties the result path. Configuration writes
// (i_cfg_we) take effect at the next edge; the user, not the block, confines them to idle.

module button_click_double_long_detector
    import bcdl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_action,
    input  logic [LEVEL_W-1:0]   i_pressed_levels,
    input  logic [IDX_W-1:0]     i_key_index,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [EV_W-1:0]      o_event_flags,
    output logic [LEVEL_W-1:0]   o_held_keys,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    t_cfg            r_cfg;
    logic            accept, tick;
    logic [EV_W-1:0] key_events [KEYS];
    logic [KEYS-1:0] held_next;
    logic            idx_ok;
    t_result         result, out_data;
    logic            busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks     <= DEBOUNCE_RST;
            r_cfg.long_press_ticks   <= LONG_RST;
            r_cfg.double_click_ticks <= DOUBLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_cfg.debounce_ticks     <= i_cfg_data;
                CFG_LONG:     r_cfg.long_press_ticks   <= i_cfg_data;
                CFG_DOUBLE:   r_cfg.double_click_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept = i_valid && !o_stall;
    assign tick   = accept && (i_action == ACT_TICK);
    assign idx_ok = ({1'b0, i_key_index} < (IDX_W+1)'(KEYS));

    for (genvar k = 0; k < KEYS; k++) begin : g_key
        logic level;
        if (k < LEVEL_W) begin : g_lvl
            assign level = i_pressed_levels[k];
        end else begin : g_nolvl
            assign level = 1'b0;
        end

        bcdl_key u_key (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cfg       (r_cfg),
            .i_tick      (tick),
            .i_level     (level),
            .i_clear     (accept && (i_action == ACT_READ) &&
                          ({1'b0, i_key_index} == (IDX_W+1)'(k))),
            .o_events    (key_events[k]),
            .o_held_next (held_next[k])
        );
    end

    // held bits of keys beyond the output width are dropped
    for (genvar b = 0; b < LEVEL_W; b++) begin : g_held
        if (b < KEYS) begin : g_on
            assign result.held_keys[b] = held_next[b];
        end else begin : g_off
            assign result.held_keys[b] = 1'b0;
        end
    end

    assign result.event_flags = ((i_action == ACT_READ) && idx_ok) ?
        key_events[i_key_index[$clog2(KEYS > 1 ? KEYS : 2)-1:0]] : '0;

    bcdl_oskid u_oskid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_data  (result),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (out_data),
        .o_busy  (busy)
    );

    assign o_stall       = busy;
    assign o_event_flags = out_data.event_flags;
    assign o_held_keys   = out_data.held_keys;

endmodule

FILE: design/bcdl_checker.sv
// bcdl_checker: port-level assertions on the button detector, bound to the top
// depends on bcdl_pkg and button_click_double_long_detector
`timescale 1ns / 1ps

module bcdl_checker
    import bcdl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  logic                 i_action,
    input  logic [LEVEL_W-1:0]   i_pressed_levels,
    input  logic [IDX_W-1:0]     i_key_index,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  logic [EV_W-1:0]      o_event_flags,
    input  logic [LEVEL_W-1:0]   o_held_keys,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event_flags) && $stable(o_held_keys))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result path not empty after reset");

    // an accepted tick with a free output shows up next cycle with no flags
    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_action == ACT_TICK) && !(o_valid && i_stall)
        |=> o_valid && (o_event_flags == '0))
        else $error("tick result missing or carries flags");

    a_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending result");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall && i_valid))
        else $error("input stall without output stall");

endmodule

bind button_click_double_long_detector bcdl_checker u_bcdl_checker (.*);

FILE: test/bcdl_checker.sv
// bcdl_scoreboard: watches the request, result and register ports of the button detector,
// predicts every result from its own copy of the key machines and compares them
// depends on bcdl_pkg
`timescale 1ns / 1ps

module bcdl_scoreboard
    import bcdl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_stall,
    input  logic                 i_action,
    input  logic [LEVEL_W-1:0]   i_pressed_levels,
    input  logic [IDX_W-1:0]     i_key_index,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic [EV_W-1:0]      i_event_flags,
    input  logic [LEVEL_W-1:0]   i_held_keys,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending_results
);

    localparam int KSEL_W = (KEYS > 1) ? $clog2(KEYS) : 1;

    t_cfg             timers;
    logic [2:0]       key_phase  [KEYS];
    logic [CNT_W-1:0] key_count  [KEYS];
    logic [EV_W-1:0]  key_events [KEYS];
    logic [KEYS-1:0]  key_held;
    t_result          key_report_q [$];

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        if (o_fail_count < 200) begin
            $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", field, want, got, $time);
        end
        o_fail_count++;
    endtask

    // one key machine, one tick; countdowns wrap at 16 bits
    task automatic advance_key(input int k, input logic p);
        case (key_phase[k])
            PH_DEBOUNCE: begin
                if (!p) begin
                    key_phase[k] = PH_IDLE;
                end else begin
                    key_count[k] = key_count[k] - 1'b1;
                    if (key_count[k] == '0) begin
                        key_held[k]  = 1'b1;
                        key_count[k] = timers.long_press_ticks;
                        key_phase[k] = PH_HELD;
                    end
                end
            end
            PH_HELD: begin
                if (!p) begin
                    key_held[k]  = 1'b0;
                    key_count[k] = timers.double_click_ticks;
                    key_phase[k] = PH_GAP;
                end else begin
                    key_count[k] = key_count[k] - 1'b1;
                    if (key_count[k] == '0) begin
                        key_events[k] = key_events[k] | EV_LONG;
                        key_phase[k]  = PH_WAIT;
                    end
                end
            end
            PH_GAP: begin
                if (p) begin
                    key_events[k] = key_events[k] | EV_DOUBLE;
                    key_held[k]   = 1'b1;
                    key_phase[k]  = PH_WAIT;
                end else begin
                    key_count[k] = key_count[k] - 1'b1;
                    if (key_count[k] == '0) begin
                        key_events[k] = key_events[k] | EV_CLICK;
                        key_phase[k]  = PH_IDLE;
                    end
                end
            end
            PH_WAIT: begin
                if (!p) begin
                    key_held[k]  = 1'b0;
                    key_phase[k] = PH_IDLE;
                end
            end
            default: begin
                if (p) begin
                    key_count[k] = timers.debounce_ticks;
                    key_phase[k] = PH_DEBOUNCE;
                end else begin
                    key_phase[k] = PH_IDLE;
                end
            end
        endcase
    endtask

    task automatic qualify_request(input logic act, input logic [LEVEL_W-1:0] levels,
                                   input logic [IDX_W-1:0] idx);
        t_result res;
        res.event_flags = '0;
        if (act == ACT_TICK) begin
            for (int k = 0; k < KEYS; k++) begin
                advance_key(k, levels[k]);
            end
        end else if (idx < KEYS) begin
            res.event_flags = key_events[idx[KSEL_W-1:0]];
            key_events[idx[KSEL_W-1:0]] = '0;
        end
        res.held_keys = key_held;
        key_report_q.push_back(res);
    endtask

    task automatic check_result();
        t_result want;
        if (key_report_q.size() == 0) begin
            report_mismatch("result with no request pending", 8'h00,
                            {1'b0, i_event_flags, i_held_keys});
        end else begin
            want = key_report_q.pop_front();
            if (want.event_flags !== i_event_flags) begin
                report_mismatch("event_flags", 8'(want.event_flags), 8'(i_event_flags));
            end
            if (want.held_keys !== i_held_keys) begin
                report_mismatch("held_keys", 8'(want.held_keys), 8'(i_held_keys));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timers.debounce_ticks     = DEBOUNCE_RST;
            timers.long_press_ticks   = LONG_RST;
            timers.double_click_ticks = DOUBLE_RST;
            for (int k = 0; k < KEYS; k++) begin
                key_phase[k]  = PH_IDLE;
                key_count[k]  = '0;
                key_events[k] = '0;
            end
            key_held = '0;
            key_report_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEBOUNCE: timers.debounce_ticks     = i_cfg_data;
                    CFG_LONG:     timers.long_press_ticks   = i_cfg_data;
                    CFG_DOUBLE:   timers.double_click_ticks = i_cfg_data;
                    default: ;
                endcase
            end
            // a result never leaves in the cycle its request is taken
            if (i_res_valid && !i_res_stall) begin
                check_result();
            end
            if (i_req_valid && !i_req_stall) begin
                qualify_request(i_action, i_pressed_levels, i_key_index);
            end
        end
        o_pending_results <= key_report_q.size();
    end

endmodule

FILE: test/tb.sv
// tb: stimulus and verdict for button_click_double_long_detector
// depends on bcdl_pkg, button_click_double_long_detector and bcdl_scoreboard
`timescale 1ns / 1ps

module tb;
    import bcdl_pkg::*;

    localparam int                   QUIET_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n          = 1'b0;
    logic                 i_valid          = 1'b0;
    logic                 i_action         = ACT_TICK;
    logic [LEVEL_W-1:0]   i_pressed_levels = '0;
    logic [IDX_W-1:0]     i_key_index      = '0;
    logic                 i_stall          = 1'b0;
    logic                 i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx        = CFG_DEBOUNCE;
    logic [CNT_W-1:0]     i_cfg_data       = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [EV_W-1:0]      o_event_flags;
    logic [LEVEL_W-1:0]   o_held_keys;

    int                   fail_count;
    int                   pending_results;
    int                   quiet_cycles     = 0;
    int                   tx_idle_pct      = 21;
    int                   rx_idle_pct      = 53;
    int unsigned          debounce_now     = 20;
    int unsigned          long_now         = 1000;
    int unsigned          double_now       = 250;
    logic [LEVEL_W-1:0]   gesture_level    = '0;
    int                   gesture_run [LEVEL_W];

    button_click_double_long_detector i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_pressed_levels (i_pressed_levels),
        .i_key_index      (i_key_index),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_flags    (o_event_flags),
        .o_held_keys      (o_held_keys),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    bcdl_scoreboard u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_valid),
        .i_req_stall       (o_stall),
        .i_action          (i_action),
        .i_pressed_levels  (i_pressed_levels),
        .i_key_index       (i_key_index),
        .i_res_valid       (o_valid),
        .i_res_stall       (i_stall),
        .i_event_flags     (o_event_flags),
        .i_held_keys       (o_held_keys),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending_results (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic act, input logic [LEVEL_W-1:0] lv,
                                input logic [IDX_W-1:0] ki);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_action         <= act;
        i_pressed_levels <= lv;
        i_key_index      <= ki;
        do @(posedge i_clk); while (o_stall);
    endtask

    // hold requests back until every result is out
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic program_timers(input logic [CNT_W-1:0] deb, input logic [CNT_W-1:0] lng,
                                  input logic [CNT_W-1:0] dbl);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DEBOUNCE;
        i_cfg_data <= deb;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LONG;
        i_cfg_data <= lng;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DOUBLE;
        i_cfg_data <= dbl;
        @(posedge i_clk);
        // no register behind this index, the write must be dropped
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= CNT_W'($urandom);
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        debounce_now = deb;
        long_now     = lng;
        double_now   = dbl;
    endtask

    function automatic logic [IDX_W-1:0] read_index();
        if ($urandom_range(0, 4) == 0) begin
            return IDX_W'($urandom_range(4, 7));
        end
        return IDX_W'($urandom_range(0, KEYS - 1));
    endfunction

    // length of the next press or release, aimed at bounce, click, double or long press
    function automatic int pick_run(input logic pressed);
        if (pressed) begin
            case ($urandom_range(0, 3))
                0:       return $urandom_range(1, debounce_now);
                3:       return $urandom_range(debounce_now + long_now + 1,
                                               debounce_now + long_now + 4);
                default: return $urandom_range(debounce_now + 1, debounce_now + long_now);
            endcase
        end
        if ($urandom_range(0, 1) == 0) begin
            return $urandom_range(1, double_now);
        end
        return $urandom_range(double_now + 1, double_now + 3);
    endfunction

    task automatic next_levels(output logic [LEVEL_W-1:0] lv);
        for (int k = 0; k < LEVEL_W; k++) begin
            if (gesture_run[k] <= 0) begin
                gesture_level[k] = ~gesture_level[k];
                gesture_run[k]   = pick_run(gesture_level[k]);
            end
            gesture_run[k]--;
        end
        lv = gesture_level;
        // single-tick glitch on one pin
        if ($urandom_range(0, 15) == 0) begin
            lv[$urandom_range(0, LEVEL_W - 1)] ^= 1'b1;
        end
    endtask

    task automatic random_item();
        if ($urandom_range(0, 3) == 0) begin
            send_request(ACT_READ, LEVEL_W'($urandom), read_index());
        end else begin
            send_request(ACT_TICK, LEVEL_W'($urandom), IDX_W'($urandom));
        end
    endtask

    task automatic gesture_item();
        logic [LEVEL_W-1:0] lv;
        if ($urandom_range(0, 63) == 0) begin
            drain();
        end
        if ($urandom_range(0, 3) == 0) begin
            send_request(ACT_READ, LEVEL_W'($urandom), read_index());
        end else begin
            next_levels(lv);
            send_request(ACT_TICK, lv, IDX_W'($urandom));
        end
    endtask

    initial begin
        for (int k = 0; k < LEVEL_W; k++) begin
            gesture_run[k] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default timers: presses far shorter than the debounce, reads of every index
        send_request(ACT_TICK, 4'hf, 3'd0);
        send_request(ACT_TICK, 4'hf, 3'd7);
        send_request(ACT_TICK, 4'h0, 3'd0);
        send_request(ACT_TICK, 4'h5, 3'd2);
        send_request(ACT_TICK, 4'ha, 3'd5);
        send_request(ACT_TICK, 4'h0, 3'd0);
        for (int k = 0; k < 8; k++) begin
            send_request(ACT_READ, 4'hf, IDX_W'(k));
        end

        // shortest timers: click on key 0, double click on key 1, long press on key 2,
        // bounce on key 3
        drain();
        program_timers(16'd1, 16'd1, 16'd1);
        send_request(ACT_TICK, 4'hf, 3'd0);
        send_request(ACT_TICK, 4'h7, 3'd0);
        send_request(ACT_TICK, 4'h4, 3'd0);
        send_request(ACT_TICK, 4'h6, 3'd0);
        send_request(ACT_TICK, 4'h0, 3'd0);
        for (int k = 0; k < KEYS; k++) begin
            send_request(ACT_READ, 4'h0, IDX_W'(k));
        end

        // longest timers, then counts of zero that wrap to a full 16-bit period
        drain();
        program_timers(16'hffff, 16'hffff, 16'hffff);
        repeat (10) random_item();
        drain();
        program_timers(16'd0, 16'd0, 16'd0);
        repeat (10) random_item();
        drain();
        program_timers(16'd1, 16'd0, 16'd0);
        repeat (12) random_item();

        drain();
        program_timers(CNT_W'($urandom_range(1, 3)), CNT_W'($urandom_range(1, 4)),
                       CNT_W'($urandom_range(1, 3)));
        repeat (220) gesture_item();

        drain();
        tx_idle_pct = 53;
        rx_idle_pct <= 21;
        program_timers(CNT_W'($urandom_range(2, 5)), CNT_W'($urandom_range(2, 8)),
                       CNT_W'($urandom_range(2, 6)));
        repeat (220) gesture_item();

        drain();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        program_timers(CNT_W'($urandom_range(1, 6)), CNT_W'($urandom_range(1, 10)),
                       CNT_W'($urandom_range(1, 6)));
        repeat (220) gesture_item();

        drain();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
design/bcdl_pkg.sv
design/bcdl_key.sv
design/bcdl_oskid.sv
design/button_click_double_long_detector.sv
design/bcdl_checker.sv
test/bcdl_checker.sv
test/tb.sv
